// ===== rtl/bit_vector_range_ops_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bit vector range ops unit
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BIT_VECTOR_RANGE_OPS_UNIT_DEFINES_SVH
`define BIT_VECTOR_RANGE_OPS_UNIT_DEFINES_SVH

// same-cycle implication
`define BVRO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BVRO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bvro_pkg.sv =====
// ----------------------------------------------------------------------------
// bvro_pkg
// Shared constants, op codes and item types of the bit vector range ops unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bvro_pkg;

   localparam int VECTOR_BITS = 1024;
   localparam int WORD_BITS   = 64;
   localparam int WORD_COUNT  = (VECTOR_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int INDEX_W     = $clog2(VECTOR_BITS);
   localparam int LEN_W       = $clog2(VECTOR_BITS + 1);
   localparam int WORD_SHIFT  = $clog2(WORD_BITS);
   localparam int STEP_W      = INDEX_W - WORD_SHIFT;   // word number within the store
   localparam int LWORD_W     = LEN_W - WORD_SHIFT;     // word number of a length
   localparam int POP_W       = $clog2(WORD_BITS + 1);
   localparam int OP_W        = 3;

   localparam logic [OP_W-1:0] OP_GET   = 3'd0;
   localparam logic [OP_W-1:0] OP_PUT   = 3'd1;
   localparam logic [OP_W-1:0] OP_SET   = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
   localparam logic [OP_W-1:0] OP_FLIP  = 3'd4;
   localparam logic [OP_W-1:0] OP_COUNT = 3'd5;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] low_index;
      logic [INDEX_W-1:0] high_index;
      logic               bit_value;
   } req_type;

   typedef struct packed {
      logic             read_bit;
      logic [LEN_W-1:0] ones_count;
      logic             error;
   } rsp_type;

   // operation context held for the whole walk over the store
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] low_index;
      logic [INDEX_W-1:0] high_index;
      logic               bit_value;
      logic               error;
      logic [LEN_W-1:0]   length;
   } ctx_type;

endpackage

`default_nettype wire

// ===== rtl/bit_vector_range_ops_unit.sv =====
// ----------------------------------------------------------------------------
// bit_vector_range_ops_unit
// Bit vector with get, put, range set/clear/flip and population count.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per request (op, low_index, high_index, bit_value).
//   rsp_*  : exactly one result item per request (read_bit, ones_count, error).
//   csr_*  : write of vector_length, the number of bits in use (reset 1024,
//            values above the store size act as the store size). Write only
//            while the unit is idle; csr_ready is always high.
// The store is a ring of 16 word cells. Every item rotates the ring once
// around: each cycle that the walk advances, the word at the head passes
// through the word unit and re-enters at the tail, so all ops cost the same.
// A walk takes 16 ring steps from request accept to rsp_valid (the last one
// loads the result register). A new item is not taken before the walk is
// done: req_ready drops while a walk is in progress and rises again once the
// last step has loaded the result register.
// Reset: synchronous; clears the whole store, sets vector_length to 1024 and
// empties the result register.
// Stall: a held result does not block a new request; a walk that finishes
// while the previous result is still unaccepted pauses on its last step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bit_vector_range_ops_unit_defines.svh"

module bit_vector_range_ops_unit (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  bvro_pkg::req_type         req_item,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output bvro_pkg::rsp_type         rsp_item,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire [bvro_pkg::LEN_W-1:0] csr_data
);
   import bvro_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_COUNT - 1);

   // config
   logic [LEN_W-1:0]  vlen_ff, vlen_in;
   logic [LEN_W-1:0]  used_len;

   // walk control
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ctx_type           ctx_ff, ctx_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              rbit_ff, rbit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   logic              req_fire, last, advance, rsp_pop;
   logic              lo_bad, hi_bad, new_err;

   // ring of word cells; the head is cell 0
   word_type          ring [WORD_COUNT];
   word_type          head_new;
   logic              hit_bit;
   logic [POP_W-1:0]  ones;
   logic [LEN_W-1:0]  cnt_sum;

   assign csr_ready = 1'b1;
   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_pop   = rsp_valid_ff && rsp_ready;
   assign last      = (step_ff == LAST_STEP);
   // final step waits while the previous result still sits unaccepted
   assign advance   = busy_ff && !(last && rsp_valid_ff && !rsp_ready);

   assign used_len  = (vlen_ff > LEN_W'(VECTOR_BITS)) ? LEN_W'(VECTOR_BITS) : vlen_ff;

   // range and op checks, done once at accept
   assign lo_bad = ({1'b0, req_item.low_index} >= used_len);
   assign hi_bad = ({1'b0, req_item.high_index} >= used_len);

   always_comb begin
      case (req_item.op)
         OP_GET, OP_PUT:            new_err = lo_bad;
         OP_SET, OP_CLEAR, OP_FLIP: new_err = lo_bad || hi_bad ||
                                             (req_item.high_index < req_item.low_index);
         OP_COUNT:                  new_err = 1'b0;
         default:                   new_err = 1'b1;
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < WORD_COUNT; gi++) begin : g_cell
         word_type shift_in;
         if (gi == WORD_COUNT - 1) begin : g_tail
            assign shift_in = head_new;
         end else begin : g_mid
            assign shift_in = ring[gi + 1];
         end
         bvro_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (advance),
            .shift_in (shift_in),
            .word_out (ring[gi])
         );
      end
   endgenerate

   bvro_word_op u_word_op (
      .ctx      (ctx_ff),
      .step     (step_ff),
      .word_in  (ring[0]),
      .word_out (head_new),
      .hit_bit  (hit_bit),
      .ones     (ones)
   );

   assign cnt_sum = cnt_ff + LEN_W'(ones);

   always_comb begin
      vlen_in      = vlen_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      ctx_in       = ctx_ff;
      cnt_in       = cnt_ff;
      rbit_in      = rbit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_item_in  = rsp_item_ff;

      if (csr_valid) begin
         vlen_in = csr_data;
      end

      if (req_fire) begin
         busy_in          = 1'b1;
         step_in          = '0;
         cnt_in           = '0;
         rbit_in          = 1'b0;
         ctx_in.op         = req_item.op;
         ctx_in.low_index  = req_item.low_index;
         ctx_in.high_index = req_item.high_index;
         ctx_in.bit_value  = req_item.bit_value;
         ctx_in.error      = new_err;
         ctx_in.length     = used_len;
      end else if (advance) begin
         step_in = step_ff + 1'b1;
         cnt_in  = cnt_sum;
         rbit_in = rbit_ff | hit_bit;
         if (last) begin
            busy_in                = 1'b0;
            step_in                = '0;
            rsp_valid_in           = 1'b1;
            rsp_item_in.read_bit   = rbit_ff | hit_bit;
            rsp_item_in.ones_count = cnt_sum;
            rsp_item_in.error      = ctx_ff.error;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff      <= LEN_W'(VECTOR_BITS);
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vlen_ff      <= vlen_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff      <= ctx_in;
      cnt_ff      <= cnt_in;
      rbit_ff     <= rbit_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `BVRO_ASSERT_NEXT(a_accept_starts_walk, req_fire, busy_ff && (step_ff == '0), "walk did not start at word zero")
   `BVRO_ASSERT_NOW(a_idle_step_zero, !busy_ff, step_ff == '0, "step counter not parked while idle")
   `BVRO_ASSERT_NEXT(a_last_step_result, advance && last, rsp_valid_ff && !busy_ff, "finished walk gave no result")
   `BVRO_ASSERT_NOW(a_result_consistent, rsp_valid_ff && (rsp_item_ff.read_bit || (rsp_item_ff.ones_count != '0)), !rsp_item_ff.error, "data reported with error set")

endmodule

`default_nettype wire

// ===== rtl/bvro_cell.sv =====
// ----------------------------------------------------------------------------
// bvro_cell
// One word of the store; takes its neighbor's word when the ring rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module bvro_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 shift_en,
   input  bvro_pkg::word_type  shift_in,
   output bvro_pkg::word_type  word_out
);
   import bvro_pkg::*;

   word_type word_ff;
   word_type word_in;

   assign word_in  = shift_en ? shift_in : word_ff;
   assign word_out = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bvro_word_op.sv =====
// ----------------------------------------------------------------------------
// bvro_word_op
// Applies the current operation to the word at the head of the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module bvro_word_op (
   input  bvro_pkg::ctx_type                 ctx,
   input  wire [bvro_pkg::STEP_W-1:0]        step,
   input  bvro_pkg::word_type                word_in,
   output bvro_pkg::word_type                word_out,
   output logic                              hit_bit,
   output logic [bvro_pkg::POP_W-1:0]        ones
);
   import bvro_pkg::*;

   localparam word_type ONES = {WORD_BITS{1'b1}};

   logic [STEP_W-1:0]     lo_w, hi_w;
   logic [WORD_SHIFT-1:0] lo_b, hi_b, len_b;
   logic [LWORD_W-1:0]    len_w, step_l;
   word_type              from_lo, to_hi, range_mask, len_mask;
   logic                  point_hit;

   assign lo_w   = ctx.low_index[INDEX_W-1:WORD_SHIFT];
   assign lo_b   = ctx.low_index[WORD_SHIFT-1:0];
   assign hi_w   = ctx.high_index[INDEX_W-1:WORD_SHIFT];
   assign hi_b   = ctx.high_index[WORD_SHIFT-1:0];
   assign len_w  = ctx.length[LEN_W-1:WORD_SHIFT];
   assign len_b  = ctx.length[WORD_SHIFT-1:0];
   assign step_l = {1'b0, step};

   always_comb begin
      if (step > lo_w)       from_lo = ONES;
      else if (step == lo_w) from_lo = ONES << lo_b;
      else                   from_lo = '0;

      if (step < hi_w)       to_hi = ONES;
      else if (step == hi_w) to_hi = ONES >> (WORD_SHIFT'(WORD_BITS - 1) - hi_b);
      else                   to_hi = '0;

      if (step_l < len_w)       len_mask = ONES;
      else if (step_l == len_w) len_mask = ~(ONES << len_b);
      else                      len_mask = '0;
   end

   assign range_mask = ctx.error ? '0 : (from_lo & to_hi);
   assign point_hit  = !ctx.error && (step == lo_w) &&
                       ((ctx.op == OP_GET) || (ctx.op == OP_PUT));
   assign hit_bit    = point_hit & word_in[lo_b];

   always_comb begin
      word_out = word_in;
      case (ctx.op)
         OP_PUT: begin
            if (point_hit) word_out[lo_b] = ctx.bit_value;
         end
         OP_SET:   word_out = word_in | range_mask;
         OP_CLEAR: word_out = word_in & ~range_mask;
         OP_FLIP:  word_out = word_in ^ range_mask;
         default:  word_out = word_in;
      endcase
   end

   assign ones = (ctx.op == OP_COUNT) ? POP_W'($countones(word_in & len_mask)) : '0;

endmodule

`default_nettype wire
